### sv/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers; clock and reset are fixed to clk_i and rst_ni.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising clock edge outside reset
`define MBP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Condition in one cycle implies a condition in the next cycle
`define MBP_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

### sv/mbp_pkg.sv
// ----------------------------------------------------------------------------
// mbp_pkg
// Types and constants shared by the bit packer modules.
// ----------------------------------------------------------------------------
package mbp_pkg;

  // Fixed field widths
  localparam int CodeW  = 32;
  localparam int CountW = 6;
  localparam int ByteW  = 8;
  localparam int TotalW = 32;
  // Working window: one partial byte plus a full code word
  localparam int AccW   = ByteW + CodeW;

  // Classified item held in the queue
  typedef struct packed {
    logic              flush;
    logic [CodeW-1:0]  code;   // masked to count bits
    logic [CountW-1:0] count;  // saturated
  } entry_t;

endpackage

### sv/mbp_front.sv
// ----------------------------------------------------------------------------
// mbp_front
// Accepts input items, saturates the bit count, masks the code and drops
// writes that append nothing.
// ----------------------------------------------------------------------------
module mbp_front #(
  parameter int MAX_CODE_BITS = 32
) (
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic                       cmd_i,
  input  logic [mbp_pkg::CodeW-1:0]  code_i,
  input  logic [mbp_pkg::CountW-1:0] code_len_i,
  output logic                       push_o,
  output mbp_pkg::entry_t            entry_o,
  input  logic                       full_i
);

  localparam int Limit = (MAX_CODE_BITS < mbp_pkg::CodeW) ? MAX_CODE_BITS : mbp_pkg::CodeW;

  logic [mbp_pkg::CountW-1:0] count_sat;
  logic [mbp_pkg::CodeW-1:0]  mask;

  // Saturate count and mask the code to its low bits
  always_comb begin
    count_sat = (code_len_i > mbp_pkg::CountW'(Limit)) ? mbp_pkg::CountW'(Limit)
                                                       : code_len_i;
    mask      = ~({mbp_pkg::CodeW{1'b1}} << count_sat);
  end

  assign in_ready_o    = !full_i;
  assign entry_o.flush = cmd_i;
  assign entry_o.code  = code_i & mask;
  assign entry_o.count = count_sat;

  // A write of zero bits has no effect and is not queued
  assign push_o = in_valid_i && !full_i && (cmd_i || (count_sat != '0));

endmodule

### sv/mbp_queue.sv
// ----------------------------------------------------------------------------
// mbp_queue
// Two-entry queue between the front and the back.
// ----------------------------------------------------------------------------
module mbp_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  mbp_pkg::entry_t entry_i,
  output logic            full_o,
  output logic            valid_o,
  output mbp_pkg::entry_t entry_o,
  input  logic            pop_i
);

  mbp_pkg::entry_t mem_q [2];
  logic            wr_ptr_q, wr_ptr_d;
  logic            rd_ptr_q, rd_ptr_d;
  logic [1:0]      fill_q, fill_d;

  // Pointer and fill update
  always_comb begin
    wr_ptr_d = push_i ? !wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop_i  ? !rd_ptr_q : rd_ptr_q;
    fill_d   = fill_q;
    if (push_i && !pop_i) begin
      fill_d = fill_q + 2'd1;
    end else if (pop_i && !push_i) begin
      fill_d = fill_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      fill_q   <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  // Payload storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

  assign full_o  = fill_q[1];
  assign valid_o = (fill_q != 2'd0);
  assign entry_o = mem_q[rd_ptr_q];

endmodule

### sv/mbp_back.sv
// ----------------------------------------------------------------------------
// mbp_back
// Merges queued codes into the bit window and emits one byte per cycle while
// the output is accepted, through a registered output stage.
// ----------------------------------------------------------------------------
module mbp_back #(
  parameter int COUNTER_BITS = 32
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       valid_i,
  input  mbp_pkg::entry_t            entry_i,
  output logic                       pop_o,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [mbp_pkg::ByteW-1:0]  data_byte_o,
  output logic                       carries_byte_o,
  output logic                       last_o,
  output logic [mbp_pkg::TotalW-1:0] total_bytes_o
);

  localparam int AccW   = mbp_pkg::AccW;
  localparam int ByteW  = mbp_pkg::ByteW;
  localparam int CountW = mbp_pkg::CountW;
  localparam int TotW   = (COUNTER_BITS < mbp_pkg::TotalW) ? COUNTER_BITS : mbp_pkg::TotalW;

  localparam logic StIdle = 1'b0;
  localparam logic StEmit = 1'b1;

  logic                        state_q, state_d;
  logic [AccW-1:0]             acc_q, acc_d;      // left-aligned pending bits
  logic [CountW-1:0]           nb_q, nb_d;        // pending bit count
  logic [COUNTER_BITS-1:0]     cnt_q, cnt_d;
  logic                        ovalid_q, ovalid_d;
  logic [ByteW-1:0]            obyte_q, obyte_d;
  logic                        ocarry_q, ocarry_d;
  logic                        olast_q, olast_d;
  logic [mbp_pkg::TotalW-1:0]  otot_q, otot_d;

  logic                        can_push;
  logic [CountW-1:0]           shamt;
  logic [AccW-1:0]             acc_load;
  logic [CountW-1:0]           nb_load;
  logic [COUNTER_BITS-1:0]     cnt_inc;
  logic [CountW-1:0]           nb_left;

  assign can_push = !ovalid_q || out_ready_i;
  assign cnt_inc  = cnt_q + COUNTER_BITS'(1);
  assign nb_left  = nb_q - CountW'(ByteW);

  // New code placed just below the bits already pending
  always_comb begin
    shamt    = CountW'(AccW) - nb_q - entry_i.count;
    acc_load = {acc_q[AccW-1 -: ByteW], {(AccW-ByteW){1'b0}}}
             | ({{ByteW{1'b0}}, entry_i.code} << shamt);
    nb_load  = nb_q + entry_i.count;
  end

  // Sequencer and output stage
  always_comb begin
    state_d  = state_q;
    acc_d    = acc_q;
    nb_d     = nb_q;
    cnt_d    = cnt_q;
    pop_o    = 1'b0;
    ovalid_d = ovalid_q && !out_ready_i;
    obyte_d  = obyte_q;
    ocarry_d = ocarry_q;
    olast_d  = olast_q;
    otot_d   = otot_q;
    unique case (state_q)
      StIdle: begin
        if (valid_i && entry_i.flush) begin
          if (can_push) begin
            pop_o    = 1'b1;
            ovalid_d = 1'b1;
            olast_d  = 1'b1;
            ocarry_d = (nb_q != '0);
            obyte_d  = acc_q[AccW-1 -: ByteW];
            otot_d   = (nb_q != '0) ? mbp_pkg::TotalW'(cnt_inc[TotW-1:0])
                                    : mbp_pkg::TotalW'(cnt_q[TotW-1:0]);
            acc_d    = '0;
            nb_d     = '0;
            cnt_d    = '0;
          end
        end else if (valid_i) begin
          pop_o = 1'b1;
          acc_d = acc_load;
          nb_d  = nb_load;
          if (nb_load >= CountW'(ByteW)) begin
            state_d = StEmit;
          end
        end
      end
      StEmit: begin
        if (can_push) begin
          ovalid_d = 1'b1;
          ocarry_d = 1'b1;
          obyte_d  = acc_q[AccW-1 -: ByteW];
          olast_d  = (nb_left < CountW'(ByteW));
          otot_d   = mbp_pkg::TotalW'(cnt_inc[TotW-1:0]);
          cnt_d    = cnt_inc;
          acc_d    = acc_q << ByteW;
          nb_d     = nb_left;
          if (nb_left < CountW'(ByteW)) begin
            state_d = StIdle;
          end
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIdle;
      acc_q    <= '0;
      nb_q     <= '0;
      cnt_q    <= '0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      acc_q    <= acc_d;
      nb_q     <= nb_d;
      cnt_q    <= cnt_d;
      ovalid_q <= ovalid_d;
    end
  end

  // Output payload
  always_ff @(posedge clk_i) begin
    obyte_q  <= obyte_d;
    ocarry_q <= ocarry_d;
    olast_q  <= olast_d;
    otot_q   <= otot_d;
  end

  assign out_valid_o    = ovalid_q;
  assign data_byte_o    = obyte_q;
  assign carries_byte_o = ocarry_q;
  assign last_o         = olast_q;
  assign total_bytes_o  = otot_q;

endmodule

### sv/msb_first_bit_packer.sv
// An item is taken when the two-entry queue has room; the back end then loads
// each write into the bit window and emits each byte it completes (up to four),
// holding while the output is not accepted, and a flush emits the final result;
// the byte output port, one byte per cycle while accepted, sets the sustained rate.
// ----------------------------------------------------------------------------
// msb_first_bit_packer
// Packs variable-length codes into bytes, first bit in bit 7, and on flush
// returns the padded partial byte, if any, with the running byte count.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module msb_first_bit_packer #(
  parameter int MAX_CODE_BITS = 32,
  parameter int COUNTER_BITS  = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // [31:0] code, [37:32] code_len, [39:38] zero
  input  logic        s_axis_tuser,   // [0] cmd
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // [7:0] data_byte, [39:8] total_bytes
  output logic        m_axis_tuser,   // [0] carries_byte
  output logic        m_axis_tlast    // last
);

  logic            push;
  logic            full;
  logic            q_valid;
  logic            pop;
  mbp_pkg::entry_t entry_in;
  mbp_pkg::entry_t entry_out;
  logic [7:0]      data_byte;
  logic [31:0]     total_bytes;
  logic            empty_item;
  logic            mid_burst;

  // Front: accept and classify
  mbp_front #(
    .MAX_CODE_BITS(MAX_CODE_BITS)
  ) u_front (
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .cmd_i      (s_axis_tuser),
    .code_i     (s_axis_tdata[31:0]),
    .code_len_i (s_axis_tdata[37:32]),
    .push_o     (push),
    .entry_o    (entry_in),
    .full_i     (full)
  );

  // Queue between front and back
  mbp_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .entry_i(entry_in),
    .full_o (full),
    .valid_o(q_valid),
    .entry_o(entry_out),
    .pop_i  (pop)
  );

  // Back: pack and emit bytes
  mbp_back #(
    .COUNTER_BITS(COUNTER_BITS)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .valid_i       (q_valid),
    .entry_i       (entry_out),
    .pop_o         (pop),
    .out_valid_o   (m_axis_tvalid),
    .out_ready_i   (m_axis_tready),
    .data_byte_o   (data_byte),
    .carries_byte_o(m_axis_tuser),
    .last_o        (m_axis_tlast),
    .total_bytes_o (total_bytes)
  );

  assign m_axis_tdata = {total_bytes, data_byte};

  // Checks
  assign empty_item = m_axis_tvalid && !m_axis_tuser;
  assign mid_burst  = m_axis_tvalid && m_axis_tready && !m_axis_tlast;
  `MBP_ASSERT(a_empty_flush_last, !empty_item || m_axis_tlast, "empty result without last")
  `MBP_ASSERT(a_empty_flush_zero, !empty_item || (data_byte == 8'd0), "empty result with data")
  `MBP_ASSERT_NEXT(a_burst_continues, mid_burst, m_axis_tvalid, "gap inside byte burst")
  `MBP_ASSERT_NEXT(a_no_pop_when_empty, !q_valid, !$past(pop), "pop from empty queue")

endmodule
